// ===== design/hau_pkg.sv =====
// hau_pkg: shared types and constants for the assignment solver.
// Used by hau_cell and hungarian_assignment_unit; no dependencies.
package hau_pkg;

    localparam int COST_W = 24;
    localparam int SIZE_W = 6;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 7;   // column/row index incl. the dummy column 0
    localparam int POT_W  = 32;

    localparam logic signed [POT_W-1:0] NO_SLACK = 32'sh7FFF_FFFF;

    // Running minimum handed from cell to cell during a scan
    typedef struct packed {
        logic                    valid;
        logic signed [POT_W-1:0] delta;
        logic [IDX_W-1:0]        best;
        logic [IDX_W-1:0]        best_owner;
        logic signed [POT_W-1:0] best_u;
    } hau_tok_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                    solve_clr;
        logic                    row_clr;
        logic                    upd;
        logic signed [POT_W-1:0] delta;
        logic [IDX_W-1:0]        best;
        logic                    aug_we;
        logic [IDX_W-1:0]        target;
        logic [IDX_W-1:0]        aug_owner;
        logic signed [POT_W-1:0] aug_u;
    } hau_ctrl_t;

endpackage

// ===== design/hau_cell.sv =====
// hau_cell: one column of the solver chain (potentials, owner, slack, path link).
// Depends on hau_pkg.
module hau_cell import hau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IDX_W-1:0]        col_id,
    input  logic                    col_en,
    input  hau_ctrl_t               ctrl,
    input  hau_tok_t                tok_in,
    input  logic [COST_W-1:0]       cost,
    input  logic [IDX_W-1:0]        cur_col,
    input  logic signed [POT_W-1:0] cur_u,
    output hau_tok_t                tok_out,
    output logic [IDX_W-1:0]        owner,
    output logic signed [POT_W-1:0] row_u,
    output logic [IDX_W-1:0]        path
);

    logic signed [POT_W-1:0] v_reg, v_next;
    logic signed [POT_W-1:0] u_reg, u_next;
    logic signed [POT_W-1:0] slack_reg, slack_next;
    logic [IDX_W-1:0]        owner_reg, owner_next;
    logic [IDX_W-1:0]        path_reg, path_next;
    logic                    vis_reg, vis_next;
    hau_tok_t                tok_reg, tok_next;
    logic signed [POT_W-1:0] red, new_slack;
    logic                    active;

    always_comb
    begin
        red       = $signed({{(POT_W-COST_W){1'b0}}, cost}) - cur_u - v_reg;
        active    = tok_in.valid && col_en && !vis_reg;
        new_slack = (red < slack_reg) ? red : slack_reg;

        tok_next       = tok_in;
        // the minimum stops past the last enabled column
        tok_next.valid = tok_in.valid && col_en;
        v_next         = v_reg;
        u_next         = u_reg;
        slack_next     = slack_reg;
        owner_next     = owner_reg;
        path_next      = path_reg;
        vis_next       = vis_reg;

        if (active)
        begin
            if (red < slack_reg)
            begin
                slack_next = red;
                path_next  = cur_col;
            end
            if (new_slack < tok_in.delta)
            begin
                tok_next.delta      = new_slack;
                tok_next.best       = col_id;
                tok_next.best_owner = owner_reg;
                tok_next.best_u     = u_reg;
            end
        end

        if (ctrl.upd && col_en)
        begin
            if (vis_reg)
            begin
                v_next = v_reg - ctrl.delta;
                u_next = u_reg + ctrl.delta;
            end
            else
            begin
                slack_next = slack_reg - ctrl.delta;
            end
            if (ctrl.best == col_id)
                vis_next = 1'b1;
        end

        if (ctrl.aug_we && ctrl.target == col_id)
        begin
            owner_next = ctrl.aug_owner;
            u_next     = ctrl.aug_u;
        end

        if (ctrl.row_clr)
        begin
            slack_next = NO_SLACK;
            vis_next   = 1'b0;
        end

        if (ctrl.solve_clr)
        begin
            v_next     = '0;
            u_next     = '0;
            owner_next = '0;
            path_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            vis_reg <= vis_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        u_reg     <= u_next;
        slack_reg <= slack_next;
        owner_reg <= owner_next;
        path_reg  <= path_next;
    end

    assign tok_out = tok_reg;
    assign owner   = owner_reg;
    assign row_u   = u_reg;
    assign path    = path_reg;

endmodule

// ===== design/hungarian_assignment_unit.sv =====
// hungarian_assignment_unit: min-cost square assignment, chain of column cells.
// Depends on hau_pkg and hau_cell. Load: one cost entry per cycle, input stalled after the last.
// Solve: a search step streams n store reads into the chain, waits for the minimum to leave cell n,
// then updates the potentials; a row adds a start state and a walk back along the path.
// Then n result transfers, one per cycle while out_stall does not hold them.
// Reset: asynchronous, active low; size reads 1, the loader is empty. No clearing pass.
module hungarian_assignment_unit import hau_pkg::*;
#(
    parameter int MAX_SIZE = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_write_en,
    input  logic [SIZE_W-1:0]    cfg_write_data,
    // cost entry input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [COST_W-1:0]    cost_value,
    // per-row result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     row_index,
    output logic [ROW_W-1:0]     assigned_column,
    output logic                 last_row
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int CIW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    // Sequencer states
    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,   // taking cost entries
        S_START = 7'b0000010,   // begin a row: clear slack/visited
        S_SCAN  = 7'b0000100,   // stream the owner's cost row into the chain
        S_WAIT  = 7'b0001000,   // wait for the running minimum to leave cell n
        S_UPD   = 7'b0010000,   // shift potentials by delta
        S_AUG   = 7'b0100000,   // walk the path back, flipping owners
        S_EMIT  = 7'b1000000    // report one row per transfer
    } state_t;

    state_t                  state_reg, state_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [LCW-1:0]          load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        cur_col_reg, cur_col_next;
    logic [IDX_W-1:0]        cur_owner_reg, cur_owner_next;
    logic signed [POT_W-1:0] cur_u_reg, cur_u_next;
    logic signed [POT_W-1:0] u0_reg, u0_next;       // potential of the row parked at column 0
    logic [IDX_W-1:0]        scan_i_reg, scan_i_next;
    logic                    first_reg, first_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [IDX_W-1:0]        best_owner_reg, best_owner_next;
    logic signed [POT_W-1:0] best_u_reg, best_u_next;
    logic signed [POT_W-1:0] delta_reg, delta_next;
    logic [IDX_W-1:0]        emit_k_reg, emit_k_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]        row_out_reg, row_out_next;
    logic [ROW_W-1:0]        col_out_reg, col_out_next;
    logic                    last_out_reg, last_out_next;

    logic [COST_W-1:0]       mem [DEPTH];
    logic [COST_W-1:0]       rd_data_reg;
    logic [AW-1:0]           rd_addr;
    logic [2*IDX_W-1:0]      row_base;

    logic [IDX_W-1:0]        n_act;
    logic [2*IDX_W-1:0]      nsq;
    logic                    in_xfer;
    logic                    out_free;

    hau_ctrl_t               ctrl;
    hau_tok_t                tok_head;
    hau_tok_t                tok [MAX_SIZE];
    hau_tok_t                tok_sel;
    logic [IDX_W-1:0]        owner_arr [MAX_SIZE];
    logic signed [POT_W-1:0] u_arr [MAX_SIZE];
    logic [IDX_W-1:0]        path_arr [MAX_SIZE];
    logic [MAX_SIZE-1:0]     tok_valid_vec;

    logic [IDX_W-1:0]        prev_col;
    logic [CIW-1:0]          emit_col;

    // size clamp: 0 acts as 1, anything above MAX_SIZE as MAX_SIZE
    always_comb
    begin
        if (size_reg == '0)
            n_act = IDX_W'(1);
        else if (IDX_W'(size_reg) > IDX_W'(MAX_SIZE))
            n_act = IDX_W'(MAX_SIZE);
        else
            n_act = IDX_W'(size_reg);
        nsq = n_act * n_act;
    end

    assign in_stall = (state_reg != S_LOAD);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // cost store: write on load, registered read during scans
    assign row_base = (cur_owner_reg - IDX_W'(1)) * n_act;
    assign rd_addr  = AW'(row_base + (2*IDX_W)'(scan_i_reg - IDX_W'(1)));

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            mem[load_cnt_reg[AW-1:0]] <= cost_value;
        rd_data_reg <= mem[rd_addr];
    end

    // the chain: column c lives in cell c-1
    always_comb
    begin
        tok_head            = '0;
        tok_head.valid      = first_reg;
        tok_head.delta      = NO_SLACK;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SIZE; g++)
        begin : g_cell
            hau_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .col_id  (IDX_W'(g + 1)),
                .col_en  (IDX_W'(g + 1) <= n_act),
                .ctrl    (ctrl),
                .tok_in  ((g == 0) ? tok_head : tok[(g == 0) ? 0 : g - 1]),
                .cost    (rd_data_reg),
                .cur_col (cur_col_reg),
                .cur_u   (cur_u_reg),
                .tok_out (tok[g]),
                .owner   (owner_arr[g]),
                .row_u   (u_arr[g]),
                .path    (path_arr[g])
            );
            assign tok_valid_vec[g] = tok[g].valid;
        end
    endgenerate

    // the running minimum leaves the chain at cell n
    assign tok_sel  = tok[CIW'(n_act - IDX_W'(1))];
    assign prev_col = (cur_col_reg == '0) ? '0 : path_arr[CIW'(cur_col_reg - IDX_W'(1))];

    // column owned by the row being reported
    always_comb
    begin
        emit_col = '0;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            if (IDX_W'(i + 1) <= n_act && owner_arr[i] == emit_k_reg + IDX_W'(1))
                emit_col = emit_col | CIW'(i);
        end
    end

    // broadcast control
    always_comb
    begin
        ctrl           = '0;
        ctrl.solve_clr = (state_reg == S_START) && (row_reg == IDX_W'(1));
        ctrl.row_clr   = (state_reg == S_START);
        ctrl.upd       = (state_reg == S_UPD);
        ctrl.delta     = delta_reg;
        ctrl.best      = best_reg;
        ctrl.aug_we    = (state_reg == S_AUG) && (cur_col_reg != '0);
        ctrl.target    = cur_col_reg;
        if (prev_col == '0)
        begin
            ctrl.aug_owner = row_reg;
            ctrl.aug_u     = u0_reg;
        end
        else
        begin
            ctrl.aug_owner = owner_arr[CIW'(prev_col - IDX_W'(1))];
            ctrl.aug_u     = u_arr[CIW'(prev_col - IDX_W'(1))];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        load_cnt_next   = load_cnt_reg;
        row_next        = row_reg;
        cur_col_next    = cur_col_reg;
        cur_owner_next  = cur_owner_reg;
        cur_u_next      = cur_u_reg;
        u0_next         = u0_reg;
        scan_i_next     = scan_i_reg;
        first_next      = 1'b0;
        best_next       = best_reg;
        best_owner_next = best_owner_reg;
        best_u_next     = best_u_reg;
        delta_next      = delta_reg;
        emit_k_next     = emit_k_reg;
        out_valid_next  = out_valid_reg && out_stall;
        row_out_next    = row_out_reg;
        col_out_next    = col_out_reg;
        last_out_next   = last_out_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if ((2*IDX_W)'(load_cnt_reg + LCW'(1)) == nsq)
                    begin
                        load_cnt_next = '0;
                        row_next      = IDX_W'(1);
                        state_next    = S_START;
                    end
                    else
                        load_cnt_next = load_cnt_reg + LCW'(1);
                end
            end
            S_START:
            begin
                cur_col_next   = '0;
                cur_owner_next = row_reg;
                cur_u_next     = '0;
                u0_next        = '0;
                scan_i_next    = IDX_W'(1);
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                first_next  = (scan_i_reg == IDX_W'(1));
                scan_i_next = scan_i_reg + IDX_W'(1);
                if (scan_i_reg == n_act)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (tok_sel.valid)
                begin
                    best_next       = tok_sel.best;
                    best_owner_next = tok_sel.best_owner;
                    best_u_next     = tok_sel.best_u;
                    delta_next      = tok_sel.delta;
                    state_next      = (tok_sel.best == '0) ? S_AUG : S_UPD;
                end
            end
            S_UPD:
            begin
                u0_next      = u0_reg + delta_reg;
                cur_col_next = best_reg;
                if (best_owner_reg != '0)
                begin
                    cur_owner_next = best_owner_reg;
                    cur_u_next     = best_u_reg;
                    scan_i_next    = IDX_W'(1);
                    state_next     = S_SCAN;
                end
                else
                    state_next = S_AUG;
            end
            S_AUG:
            begin
                if (cur_col_reg == '0)
                begin
                    if (row_reg == n_act)
                    begin
                        emit_k_next = '0;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        row_next   = row_reg + IDX_W'(1);
                        state_next = S_START;
                    end
                end
                else
                    cur_col_next = prev_col;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    row_out_next   = ROW_W'(emit_k_reg);
                    col_out_next   = ROW_W'(emit_col);
                    last_out_next  = (emit_k_reg + IDX_W'(1) == n_act);
                    emit_k_next    = emit_k_reg + IDX_W'(1);
                    if (emit_k_reg + IDX_W'(1) == n_act)
                        state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // register write: the user must write only while idle; the block does not enforce it. A partial load restarts
        if (cfg_write_en)
        begin
            size_next     = cfg_write_data;
            load_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            size_reg      <= SIZE_W'(1);
            load_cnt_reg  <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            load_cnt_reg  <= load_cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        cur_col_reg    <= cur_col_next;
        cur_owner_reg  <= cur_owner_next;
        cur_u_reg      <= cur_u_next;
        u0_reg         <= u0_next;
        scan_i_reg     <= scan_i_next;
        best_reg       <= best_next;
        best_owner_reg <= best_owner_next;
        best_u_reg     <= best_u_next;
        delta_reg      <= delta_next;
        emit_k_reg     <= emit_k_next;
        row_out_reg    <= row_out_next;
        col_out_reg    <= col_out_next;
        last_out_reg   <= last_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign row_index       = row_out_reg;
    assign assigned_column = col_out_reg;
    assign last_row        = last_out_reg;

    // at most one running minimum travels the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one scan token in the chain");

    // an update always names a real column
    a_upd_best: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> best_reg != '0)
        else $error("potential update without a chosen column");

    // the flagged result is the final row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_row |-> IDX_W'(row_index) == n_act - IDX_W'(1))
        else $error("last flag on a row other than n-1");

endmodule
